// File: rtl/core/eilc_pkg.sv
// Shared types, codes and helpers for the edge interrupt line controller.
// No dependencies; imported by every module of the block.
package eilc_pkg;

	localparam int GROUP_COUNT = 3;
	localparam int GROUP_W     = 32;
	localparam int GROUP_IDX_W = 2;
	localparam int LINE_IDX_W  = 7;
	localparam int BIT_IDX_W   = 5;
	localparam int LINE_COUNT_DEF = 96;

	// Request kinds
	localparam logic [1:0] KIND_READ   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	// Register kinds, address bits 7..5
	localparam logic [2:0] REG_IMASK  = 3'd0;
	localparam logic [2:0] REG_EMASK  = 3'd1;
	localparam logic [2:0] REG_RISE   = 3'd2;
	localparam logic [2:0] REG_FALL   = 3'd3;
	localparam logic [2:0] REG_SWTRIG = 3'd4;
	localparam logic [2:0] REG_PEND   = 3'd5;

	typedef logic [GROUP_COUNT-1:0][GROUP_W-1:0] grp_vec_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [7:0]             address;
		logic [GROUP_W-1:0]     write_data;
		logic [GROUP_IDX_W-1:0] group;
		logic [GROUP_W-1:0]     levels;
	} req_t;

	// Bits of group g that correspond to lines below line_count.
	function automatic logic [GROUP_W-1:0] line_mask(input int g, input int line_count);
		logic [GROUP_W-1:0] m;
		m = '0;
		for (int b = 0; b < GROUP_W; b++) begin
			m[b] = ((g * GROUP_W + b) < line_count);
		end
		return m;
	endfunction

endpackage

// File: rtl/core/eilc_regs.sv
// Register file of the controller: masks, edge selects, pending, last levels.
// Applies one request per update strobe. Depends on eilc_pkg.
module eilc_regs #(
	parameter int LINE_COUNT = eilc_pkg::LINE_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd,
	input  eilc_pkg::req_t               req,
	output logic [eilc_pkg::GROUP_W-1:0] rdata,
	output eilc_pkg::grp_vec_t           act
);
	import eilc_pkg::*;

	grp_vec_t imask_q, emask_q, rise_q, fall_q, pend_q, prev_q;
	grp_vec_t imask_d, emask_d, rise_d, fall_d, pend_d, prev_d;
	grp_vec_t lmask;

	logic [2:0]             reg_sel;
	logic [GROUP_IDX_W-1:0] reg_grp;
	logic                   map_ok;
	logic [GROUP_W-1:0]     wd, cur, rise_e, fall_e;

	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			lmask[g] = line_mask(g, LINE_COUNT);
		end
	end

	assign reg_sel = req.address[7:5];
	assign reg_grp = req.address[3:2];
	assign map_ok  = (reg_sel <= REG_PEND) && !req.address[4] && (req.address[1:0] == 2'b00)
		&& (reg_grp != 2'd3);

	always_comb begin
		imask_d = imask_q;
		emask_d = emask_q;
		rise_d  = rise_q;
		fall_d  = fall_q;
		pend_d  = pend_q;
		prev_d  = prev_q;
		rdata   = '0;
		wd      = '0;
		cur     = '0;
		rise_e  = '0;
		fall_e  = '0;
		if (req.kind == KIND_READ && map_ok) begin
			unique case (reg_sel)
				REG_IMASK: rdata = imask_q[reg_grp];
				REG_EMASK: rdata = emask_q[reg_grp];
				REG_RISE:  rdata = rise_q[reg_grp];
				REG_FALL:  rdata = fall_q[reg_grp];
				REG_PEND:  rdata = pend_q[reg_grp];
				default:   rdata = '0;
			endcase
		end else if (req.kind == KIND_WRITE && map_ok) begin
			wd = req.write_data & lmask[reg_grp];
			unique case (reg_sel)
				REG_IMASK:  imask_d[reg_grp] = wd;
				REG_EMASK:  emask_d[reg_grp] = wd;
				REG_RISE:   rise_d[reg_grp]  = wd;
				REG_FALL:   fall_d[reg_grp]  = wd;
				REG_SWTRIG: pend_d[reg_grp]  = pend_q[reg_grp] | wd;
				default:    pend_d[reg_grp]  = pend_q[reg_grp] & ~wd;
			endcase
		end else if (req.kind == KIND_SAMPLE && req.group != 2'd3) begin
			cur    = req.levels & lmask[req.group];
			rise_e = cur & ~prev_q[req.group];
			fall_e = prev_q[req.group] & ~cur;
			pend_d[req.group] = pend_q[req.group]
				| (((rise_e & rise_q[req.group]) | (fall_e & fall_q[req.group]))
				& lmask[req.group]);
			prev_d[req.group] = cur;
		end
	end

	// Active lines after this request's update
	assign act = pend_d & imask_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imask_q <= '0;
			emask_q <= '0;
			rise_q  <= '0;
			fall_q  <= '0;
			pend_q  <= '0;
			prev_q  <= '0;
		end else if (upd) begin
			imask_q <= imask_d;
			emask_q <= emask_d;
			rise_q  <= rise_d;
			fall_q  <= fall_d;
			pend_q  <= pend_d;
			prev_q  <= prev_d;
		end
	end

endmodule

// File: rtl/core/eilc_prio.sv
// Priority encoder: lowest active line across all groups.
// Depends on eilc_pkg.
module eilc_prio (
	input  eilc_pkg::grp_vec_t              act,
	output logic                            irq,
	output logic [eilc_pkg::LINE_IDX_W-1:0] lowest
);
	import eilc_pkg::*;

	logic [GROUP_COUNT-1:0]                    hit;
	logic [GROUP_COUNT-1:0][BIT_IDX_W-1:0]     idx;

	// Per-group lowest set bit, scanned from the top so the lowest wins
	always_comb begin
		for (int g = 0; g < GROUP_COUNT; g++) begin
			hit[g] = |act[g];
			idx[g] = '0;
			for (int b = GROUP_W - 1; b >= 0; b--) begin
				if (act[g][b]) begin
					idx[g] = BIT_IDX_W'(b);
				end
			end
		end
	end

	always_comb begin
		irq    = 1'b1;
		lowest = '0;
		priority if (hit[0]) begin
			lowest = {2'd0, idx[0]};
		end else if (hit[1]) begin
			lowest = {2'd1, idx[1]};
		end else if (hit[2]) begin
			lowest = {2'd2, idx[2]};
		end else begin
			irq = 1'b0;
		end
	end

endmodule

// File: rtl/core/edge_interrupt_line_controller.sv
// Top level of the edge interrupt line controller.
// Instantiates eilc_regs and eilc_prio; depends on eilc_pkg.
//
// Edge interrupt controller for up to LINE_COUNT lines in three groups of 32.
// Each request is a bus read, a bus write, or a level sample of one group;
// every request yields exactly one result with read data, the interrupt flag
// and the lowest pending unmasked line, both taken after the request's update.
// Registers per group sit at address = kind * 0x20 + group * 4: interrupt mask,
// event mask, rising select, falling select, software trigger (write ones to
// set pending, reads zero) and pending (write one to clear). Unmapped reads
// return zero and unmapped writes are dropped; samples for group 3 are dropped.
// Throughput is one request per clock while out_ready is high. A request is
// captured in the input register, then the register update, edge detect and
// priority encode run combinationally into the result register. The result
// register and the input register form a two-entry path, so a new request is
// taken while a finished result waits for out_ready.
module edge_interrupt_line_controller #(
	parameter int LINE_COUNT = eilc_pkg::LINE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      address,
	input  logic [eilc_pkg::GROUP_W-1:0]    write_data,
	input  logic [eilc_pkg::GROUP_IDX_W-1:0] group,
	input  logic [eilc_pkg::GROUP_W-1:0]    levels,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [eilc_pkg::GROUP_W-1:0]    read_data,
	output logic                            irq_out,
	output logic [eilc_pkg::LINE_IDX_W-1:0] lowest_line
);
	import eilc_pkg::*;

	req_t                  req_s1;
	logic                  vld_s1;
	logic                  adv;
	logic [GROUP_W-1:0]    rdata;
	grp_vec_t              act;
	logic                  irq;
	logic [LINE_IDX_W-1:0] lowest;

	logic [GROUP_W-1:0]    rdata_q;
	logic                  irq_q;
	logic [LINE_IDX_W-1:0] lowest_q;
	logic                  out_vld_q;

	// Stage 1 moves into the result register when that slot is free or draining
	assign adv      = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Request payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{kind: kind, address: address, write_data: write_data,
				group: group, levels: levels};
		end
	end

	eilc_regs #(
		.LINE_COUNT(LINE_COUNT)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.req    (req_s1),
		.rdata  (rdata),
		.act    (act)
	);

	eilc_prio u_prio (
		.act    (act),
		.irq    (irq),
		.lowest (lowest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q  <= rdata;
			irq_q    <= irq;
			lowest_q <= lowest;
		end
	end

	assign out_valid   = out_vld_q;
	assign read_data   = rdata_q;
	assign irq_out     = irq_q;
	assign lowest_line = lowest_q;

endmodule

// File: rtl/core/eilc_check.sv
// Port-level checker for the edge interrupt line controller, with its bind.
// Depends on eilc_pkg and edge_interrupt_line_controller.
module eilc_check #(
	parameter int LINE_COUNT = eilc_pkg::LINE_COUNT_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [eilc_pkg::GROUP_W-1:0]     read_data,
	input logic                             irq_out,
	input logic [eilc_pkg::LINE_IDX_W-1:0]  lowest_line
);
	import eilc_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
		&& $stable(irq_out) && $stable(lowest_line))
		else $error("result changed while stalled");

	// Input side never blocks when the result slot is free or draining
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with room downstream");

	// No interrupt means line zero is reported
	a_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !irq_out |-> lowest_line == '0)
		else $error("lowest line nonzero without interrupt");

	// Reported line exists
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && irq_out |-> int'(lowest_line) < LINE_COUNT)
		else $error("lowest line beyond line count");

endmodule

bind edge_interrupt_line_controller eilc_check #(
	.LINE_COUNT(LINE_COUNT)
) u_eilc_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.read_data   (read_data),
	.irq_out     (irq_out),
	.lowest_line (lowest_line)
);
